// File: design/ptw_pkg.sv
// Shared types and constants for the four-level page table engine.
// No dependencies. Imported by every other file of the block.
package ptw_pkg;

  localparam int TABLE_FRAMES_DEF = 64;
  localparam int IDX_W            = 9;
  localparam int VA_W             = 48;
  localparam int PA_W             = 52;
  localparam int ENTRY_W          = 64;
  localparam int FLAGS_W          = 12;
  localparam int PW_W             = 6;
  localparam int PFN_W            = PA_W - 12;

  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 52;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE = 1'b1;

  localparam logic [1:0] CMD_MAP       = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_TABLE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] LEVEL_LEAF = 2'd3;
  localparam logic [PW_W-1:0] PW_RESET = 6'd52;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear;
    logic       load_req;
    logic       step;
    logic       load_out;
    logic [1:0] level;
  } ptw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       clear_done;
    logic       is_nop;
    logic [1:0] step_st;
    logic       out_free;
  } ptw_sts_t;

endpackage

// File: design/ptw_ctrl.sv
// Walk controller of the page table engine: clearing pass, level sequencing, result hand-off.
// Depends on ptw_pkg.
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ptw_sts_t sts_i,
  output ptw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      level_q <= 2'd0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_done) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RD;
            level_q <= 2'd0;
          end
        end
        S_RD: begin
          state_q <= sts_i.is_nop ? S_OUT : S_CHK;
        end
        S_CHK: begin
          if (level_q == LEVEL_LEAF || sts_i.step_st != ST_DONE) begin
            state_q <= S_OUT;
          end else begin
            level_q <= level_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_OUT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.clear    = (state_q == S_CLEAR);
  assign cmd_o.load_req = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.step     = (state_q == S_CHK);
  assign cmd_o.load_out = (state_q == S_OUT) && sts_i.out_free;
  assign cmd_o.level    = level_q;

endmodule

// File: design/ptw_dpath.sv
// Datapath of the page table engine: table store, request and result registers, configuration.
// Depends on ptw_pkg; driven by ptw_ctrl through ptw_cmd_t.
module ptw_dpath
  import ptw_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic [IN_TUSER_W-1:0]  in_user_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic [OUT_TUSER_W-1:0] out_user_o,
  input  ptw_cmd_t               cmd_i,
  output ptw_sts_t               sts_o
);

  localparam int FRAME_W = $clog2(TABLE_FRAMES);
  localparam int NF_W    = $clog2(TABLE_FRAMES + 1);
  localparam int ADDR_W  = FRAME_W + IDX_W;
  localparam int DEPTH   = TABLE_FRAMES * (2 ** IDX_W);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [NF_W-1:0]   NF_FULL   = NF_W'(TABLE_FRAMES);

  // Configuration registers.
  logic [PW_W-1:0]  phys_width_q;
  logic [PFN_W-1:0] base_pfn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_width_q <= PW_RESET;
      base_pfn_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHYS_WIDTH: phys_width_q <= cfg_wdata_i[PW_W-1:0];
        CFG_TABLE_BASE: base_pfn_q   <= cfg_wdata_i[PA_W-1:12];
        default: ;
      endcase
    end
  end

  // Request registers.
  logic [1:0]         cmd_q;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    pa_q;
  logic [FLAGS_W-1:0] flags_q;
  logic               nx_q;
  logic               free_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      cmd_q   <= in_user_i[1:0];
      va_q    <= in_data_i[VA_W-1:0];
      pa_q    <= in_data_i[VA_W+PA_W-1:VA_W];
      flags_q <= in_data_i[VA_W+PA_W+FLAGS_W-1:VA_W+PA_W];
      nx_q    <= in_data_i[VA_W+PA_W+FLAGS_W];
      free_q  <= in_data_i[VA_W+PA_W+FLAGS_W+1];
    end
  end

  // Table store: one write port, one registered read port.
  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  walk_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[walk_addr];
  end

  // Clearing pass counter.
  logic [ADDR_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear && clr_cnt_q != LAST_ADDR) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // Walk address: current frame and the index of the current level.
  logic [FRAME_W-1:0] frame_q;
  logic [IDX_W-1:0]   idx;

  always_comb begin
    case (cmd_i.level)
      2'd0:    idx = va_q[47:39];
      2'd1:    idx = va_q[38:30];
      2'd2:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign walk_addr = {frame_q, idx};

  // Upper level decision.
  logic [NF_W-1:0]    next_free_q;
  logic [PFN_W-1:0]   diff;
  logic               frame_ok;
  logic               present;
  logic               is_leaf;
  logic               is_map;
  logic               full;
  logic               alloc;
  logic [1:0]         step_st;
  logic [ENTRY_W-1:0] alloc_entry;

  assign present  = rdata_q[0];
  assign diff     = rdata_q[PA_W-1:12] - base_pfn_q;
  assign frame_ok = (diff < PFN_W'(TABLE_FRAMES));
  assign is_leaf  = (cmd_i.level == LEVEL_LEAF);
  assign is_map   = (cmd_q == CMD_MAP);
  assign full     = (next_free_q >= NF_FULL);
  assign alloc    = !is_leaf && !present && is_map && !full;

  assign alloc_entry = {12'b0, base_pfn_q + PFN_W'(next_free_q), 12'h007};

  always_comb begin
    step_st = ST_DONE;
    if (!is_leaf) begin
      if (present) begin
        if (!frame_ok) step_st = ST_NO_TABLE;
      end else if (!is_map) begin
        step_st = ST_NO_TABLE;
      end else if (full) begin
        step_st = ST_FULL;
      end
    end
  end

  // Translate mask: bits below phys_width, page offset excluded.
  logic [PA_W-1:0] xlate_mask;

  always_comb begin
    for (int i = 0; i < PA_W; i++) begin
      xlate_mask[i] = (i >= 12) && (PW_W'(i) < phys_width_q);
    end
  end

  // Store write selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_addr;
    mem_wdata = '0;
    if (cmd_i.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (cmd_i.step) begin
      if (alloc) begin
        mem_we    = 1'b1;
        mem_wdata = alloc_entry;
      end else if (is_leaf && is_map) begin
        mem_we    = 1'b1;
        mem_wdata = {nx_q, 11'b0, pa_q | {{(PA_W-FLAGS_W){1'b0}}, flags_q}};
      end else if (is_leaf && cmd_q == CMD_UNMAP) begin
        mem_we = 1'b1;
      end
    end
  end

  // Frame pointer and free frame counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      frame_q <= '0;
    end else if (cmd_i.step && !is_leaf && step_st == ST_DONE) begin
      frame_q <= alloc ? next_free_q[FRAME_W-1:0] : diff[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= NF_W'(1);
    end else if (cmd_i.step && alloc) begin
      next_free_q <= next_free_q + NF_W'(1);
    end
  end

  // Result staging registers.
  logic [1:0]      res_st_q;
  logic [PA_W-1:0] res_addr_q;
  logic            res_rel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      res_st_q   <= ST_DONE;
      res_addr_q <= '0;
      res_rel_q  <= 1'b0;
    end else if (cmd_i.step) begin
      if (!is_leaf) begin
        res_st_q <= step_st;
      end else begin
        case (cmd_q)
          CMD_UNMAP: begin
            if (free_q) begin
              res_addr_q <= {rdata_q[PA_W-1:12], 12'b0};
              res_rel_q  <= 1'b1;
            end
          end
          CMD_TRANSLATE: begin
            res_addr_q <= (rdata_q[PA_W-1:0] & xlate_mask) |
                          {{(PA_W-12){1'b0}}, va_q[11:0]};
          end
          default: ;
        endcase
      end
    end
  end

  // Output register.
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TUSER_W-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {{(OUT_TDATA_W-PA_W){1'b0}}, res_addr_q};
      out_user_q <= {res_rel_q, res_st_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  assign sts_o.clear_done = cmd_i.clear && (clr_cnt_q == LAST_ADDR);
  assign sts_o.is_nop     = (cmd_q != CMD_MAP) && (cmd_q != CMD_UNMAP) &&
                            (cmd_q != CMD_TRANSLATE);
  assign sts_o.step_st    = step_st;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: design/four_level_page_table_engine.sv
// Top level of the four-level page table engine.
// Depends on ptw_pkg, ptw_ctrl and ptw_dpath.
//
// The engine keeps a four-level page table in a local store of TABLE_FRAMES frames of
// 512 entries each; frame 0 is the root table. Requests arrive on the slave stream with
// the command in tuser (0 map, 1 unmap, 2 translate) and the address operands in tdata.
// Each request yields exactly one response transaction on the master stream: tuser
// carries the status and the release flag, tdata the translated or released address.
//
// A request walks the table one level at a time through a store with one write port and a
// registered read port: each level takes a read state and a decision state, and the
// hand-off to the output register follows in a state of its own. A walk that fails at an
// upper level goes to the hand-off from that decision, and an unused command goes there
// straight from the read. One request is in flight at a time; the next is accepted once
// the previous response has been moved into the output register, so a response may wait
// for the receiver while the next request is being walked.
//
// After reset all TABLE_FRAMES * 512 store entries (32768 at the default size) are swept
// to zero, one entry per cycle; s_axis_tready stays low until the sweep ends.
// The configuration port may be written at any time the engine is idle, also during the
// sweep. When the receiver holds m_axis_tready low the response is held stable and the
// engine stops at the end of its next walk.
module four_level_page_table_engine
  import ptw_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // virt_addr[47:0], phys_addr[99:48], entry_flags[111:100], no_execute[112],
  // free_page[113], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_addr[51:0], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status[1:0], release_valid[2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptw_dpath #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: design/ptw_sva.sv
// Port-level checks for the four-level page table engine, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_engine.
module ptw_sva
  import ptw_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // A stalled response stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("response dropped while stalled");

  // Only one walk at a time: no acceptance in the cycle after an acceptance.
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted during a walk");

  // A page is only released by a successful unmap.
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_DONE)
    else $error("release flagged on a failed request");

  // A failed request returns no address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] != ST_DONE |-> m_axis_tdata == '0 && !m_axis_tuser[2])
    else $error("failed request carries an address");

endmodule

bind four_level_page_table_engine ptw_sva u_ptw_sva (.*);

// File: verif/tb_four_level_page_table_engine.sv
// Self-checking testbench for the four-level page table engine.
// Depends on ptw_pkg and four_level_page_table_engine; needs nothing else to run.
// Requests stream in from a queue, responses are checked against a local table walker.
`timescale 1ns / 100ps

module tb_four_level_page_table_engine;
  import ptw_pkg::*;

  localparam int FRAMES = TABLE_FRAMES_DEF;
  localparam int FRAME_ENTRIES = 512;
  // The command field has one code that the engine leaves undefined; it must act as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PRESSURE_AT = 150;    // accepted requests before the long receiver hold
  localparam int PRESSURE_LEN = 600;   // length of that hold, in cycles
  localparam int SETTLE_CYCLES = 20;   // pause after a phase has drained

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] va;
    logic [51:0] pa;
    logic [11:0] flags;
    logic        nx;
    logic        free;
  } ptw_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] addr;
    logic        rel;
  } ptw_resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  four_level_page_table_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the engine's state and configuration.
  bit [63:0]       page_store [FRAMES*FRAME_ENTRIES];
  int unsigned     next_frame = 1;
  logic [PW_W-1:0] cfg_pw = PW_RESET;
  logic [51:0]     cfg_base = '0;

  ptw_req_t  req_q [$];
  ptw_resp_t pending_resps [$];
  ptw_req_t  cur_req;
  ptw_resp_t want;
  int        queued_total = 0;
  int        accepted_total = 0;
  int        send_gap = 0;
  int        ready_gap = 0;
  int        hold_cycles = 0;
  bit        pressure_done = 1'b0;
  bit        quiet = 1'b0;
  bit        failed = 1'b0;

  // Index pools so that most requests revisit the same table paths.
  logic [8:0] top_pool [4];
  logic [8:0] mid_pool [3];
  logic [8:0] low_pool [3];

  // Walks the three upper levels, allocating absent tables when asked to.
  function automatic logic [1:0] walk_tables(input logic [47:0] va, input bit alloc,
                                             output int unsigned leaf);
    int unsigned frame;
    int unsigned slot;
    logic [63:0] ent;
    logic [51:0] diff;
    int lvl;
    frame = 0;
    leaf = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      slot = frame * FRAME_ENTRIES + va[39-9*lvl +: 9];
      ent = page_store[slot];
      if (ent[0]) begin
        // Entries hold absolute addresses, so a moved base can make them point elsewhere.
        diff = {ent[51:12], 12'h000} - {cfg_base[51:12], 12'h000};
        if (diff[51:12] >= 40'(FRAMES)) return ST_NO_TABLE;
        frame = 32'(diff[51:12]);
      end else begin
        if (!alloc) return ST_NO_TABLE;
        if (next_frame >= FRAMES) return ST_FULL;
        frame = next_frame;
        next_frame++;
        page_store[slot] = {12'h000, cfg_base[51:12] + 40'(frame), 12'h007};
      end
    end
    leaf = frame;
    return ST_DONE;
  endfunction

  // Applies one request to the local tables and returns the response it should give.
  function automatic ptw_resp_t apply_request(input ptw_req_t r);
    ptw_resp_t res;
    int unsigned leaf;
    int unsigned slot;
    logic [63:0] keep;
    res = '0;
    case (r.cmd)
      CMD_MAP: begin
        res.status = walk_tables(r.va, 1'b1, leaf);
        if (res.status == ST_DONE) begin
          slot = leaf * FRAME_ENTRIES + r.va[20:12];
          page_store[slot] = {12'h000, r.pa} | {52'h0, r.flags} | {r.nx, 63'h0};
        end
      end
      CMD_UNMAP: begin
        res.status = walk_tables(r.va, 1'b0, leaf);
        if (res.status == ST_DONE) begin
          slot = leaf * FRAME_ENTRIES + r.va[20:12];
          if (r.free) begin
            res.addr = {page_store[slot][51:12], 12'h000};
            res.rel = 1'b1;
          end
          page_store[slot] = '0;
        end
      end
      CMD_TRANSLATE: begin
        res.status = walk_tables(r.va, 1'b0, leaf);
        if (res.status == ST_DONE) begin
          slot = leaf * FRAME_ENTRIES + r.va[20:12];
          keep = ((64'd1 << cfg_pw) - 64'd1) & ~64'hfff;
          res.addr = (page_store[slot][51:0] & keep[51:0]) | {40'h0, r.va[11:0]};
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [51:0] rnd52();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[51:0];
  endfunction

  task automatic queue_req(input logic [1:0] cmd, input logic [47:0] va,
                           input logic [51:0] pa, input logic [11:0] flags,
                           input logic nx, input logic free);
    ptw_req_t r;
    r.cmd = cmd;
    r.va = va;
    r.pa = pa;
    r.flags = flags;
    r.nx = nx;
    r.free = free;
    req_q.push_back(r);
    queued_total++;
  endtask

  // Mostly well-formed traffic on a few table paths, with some fully random addresses
  // that allocate fresh tables until the store runs out.
  task automatic queue_random(input int n);
    logic [1:0] cmd;
    logic [47:0] va;
    logic [51:0] pa;
    logic [8:0] leaf_idx;
    logic [11:0] offs;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_MAP;
      else if (pick < 65) cmd = CMD_UNMAP;
      else if (pick < 97) cmd = CMD_TRANSLATE;
      else cmd = CMD_UNUSED;
      leaf_idx = ($urandom_range(0, 4) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 7));
      offs = (cmd == CMD_TRANSLATE || $urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'h000;
      if ($urandom_range(0, 19) == 0) begin
        va = 48'(rnd52());
      end else begin
        va = {top_pool[$urandom_range(0, 3)], mid_pool[$urandom_range(0, 2)],
              low_pool[$urandom_range(0, 2)], leaf_idx, offs};
      end
      pa = rnd52();
      if ($urandom_range(0, 9) < 7) pa[11:0] = 12'h000;
      queue_req(cmd, va, pa, 12'($urandom()), 1'($urandom()), 1'($urandom()));
    end
  endtask

  // Register writes go to the engine and to the local copy together; only called when idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PHYS_WIDTH) cfg_pw = data[PW_W-1:0];
    else cfg_base = data[51:0];
  endtask

  // Waits until every queued request has been accepted and answered, then settles.
  task automatic wait_drained();
    while (accepted_total != queued_total || pending_resps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [PW_W-1:0] pw, input logic [51:0] base, input int n);
    write_reg(CFG_PHYS_WIDTH, CFG_DATA_W'(pw));
    write_reg(CFG_TABLE_BASE, base);
    queue_random(n);
    wait_drained();
  endtask

  // Request driver: holds an offered transaction until it is taken, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_resps.push_back(apply_request(cur_req));
        accepted_total++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 16);
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'h00, cur_req.free, cur_req.nx, cur_req.flags,
                           cur_req.pa, cur_req.va};
          s_axis_tuser <= cur_req.cmd;
        end
      end
    end
  end

  // Response monitor and receiver back-pressure, including one long hold that lets the
  // engine fill up and stall its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_gap = 0;
      hold_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_resps.size() == 0) begin
          $error("response transaction with no request outstanding");
          failed = 1'b1;
        end else begin
          want = pending_resps.pop_front();
          if (m_axis_tuser[1:0] !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser[1:0]);
            failed = 1'b1;
          end
          if (m_axis_tdata[51:0] !== want.addr) begin
            $error("result_addr mismatch: expected %h, actual %h", want.addr,
                   m_axis_tdata[51:0]);
            failed = 1'b1;
          end
          if (m_axis_tuser[2] !== want.rel) begin
            $error("release_valid mismatch: expected %0d, actual %0d", want.rel,
                   m_axis_tuser[2]);
            failed = 1'b1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (!pressure_done && accepted_total >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_cycles = PRESSURE_LEN;
        m_axis_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        ready_gap = $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    top_pool = '{9'h000, 9'h1ff, 9'($urandom()), 9'($urandom())};
    mid_pool = '{9'h000, 9'h1ff, 9'($urandom())};
    low_pool = '{9'h000, 9'h1ff, 9'($urandom())};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset configuration: missing tables on an empty root, the
    // extremes of every field, release reporting, a translate of a cleared leaf and the
    // unused command.
    write_reg(CFG_PHYS_WIDTH, CFG_DATA_W'(PW_RESET));
    write_reg(CFG_TABLE_BASE, '0);
    queue_req(CMD_TRANSLATE, 48'h0000_0000_0000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_UNMAP, 48'h0000_0000_0000, '0, '0, 1'b0, 1'b1);
    queue_req(CMD_MAP, 48'h0000_0000_0000, 52'hF_FFFF_FFFF_FFFF, 12'hFFF, 1'b1, 1'b0);
    queue_req(CMD_TRANSLATE, 48'h0000_0000_0FFF, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_MAP, 48'hFFFF_FFFF_F000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_MAP, 48'h0000_0000_1000, 52'h0_1234_5678_9000, 12'h063, 1'b0, 1'b0);
    queue_req(CMD_TRANSLATE, 48'h0000_0000_1ABC, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_UNMAP, 48'h0000_0000_1000, '0, '0, 1'b0, 1'b1);
    queue_req(CMD_TRANSLATE, 48'h0000_0000_1234, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_UNMAP, 48'h0000_0000_0000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_UNMAP, 48'h0000_0000_0000, '0, '0, 1'b0, 1'b1);
    queue_req(CMD_UNUSED, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF, 1'b1, 1'b1);
    queue_req(CMD_UNUSED, 48'h0000_0000_0000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_TRANSLATE, 48'h0080_0000_0000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_MAP, 48'h0000_0020_0FFF, 52'hA_5A5A_5A5A_5000, 12'h5A5, 1'b1, 1'b0);
    queue_req(CMD_TRANSLATE, 48'h0000_0020_0000, '0, '0, 1'b0, 1'b0);
    queue_req(CMD_UNMAP, 48'h7F80_0000_0000, '0, '0, 1'b0, 1'b1);
    queue_req(CMD_UNMAP, 48'hFFFF_FFFF_F000, '0, '0, 1'b0, 1'b1);
    wait_drained();

    // Random phases across the register settings. A moved table base makes old entries
    // alias other frames or fall outside the store.
    run_phase(6'd52, 52'h0, 400);
    run_phase(6'd32, 52'h0, 250);
    run_phase(6'd63, 52'h0, 200);
    run_phase(6'd0, 52'h0, 150);
    run_phase(6'd40, 52'hF_FFFF_FFFF_F000, 200);
    run_phase(6'd12, 52'h0_0000_0000_0123, 200);
    run_phase(6'($urandom_range(32, 52)), {rnd52() >> 12, 12'h000}, 150);
    // The closing phase runs without any idling on either side.
    quiet = 1'b1;
    run_phase(6'd52, 52'h0, 250);

    if (!failed && pending_resps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run including the clearing sweep.
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
